// ===== rtl/transport_tpdu_header_parser_core_assert.svh =====
// Assertion macros shared by the parser modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TRANSPORT_TPDU_HEADER_PARSER_CORE_ASSERT_SVH
`define TRANSPORT_TPDU_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TPDU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define TPDU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPDU_ASSERT_IMP(lbl, ante, cons, msg)
`define TPDU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tpdu_hp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpdu_hp_pkg;

    // TPDU codes on the wire
    localparam logic [7:0] CODE_CR = 8'hE0;
    localparam logic [7:0] CODE_CC = 8'hD0;
    localparam logic [7:0] CODE_DT = 8'hF0;
    localparam logic [7:0] CODE_DR = 8'h80;
    localparam logic [7:0] CODE_ER = 8'h70;

    // Decoded kind
    localparam logic [2:0] KIND_CR = 3'd0;
    localparam logic [2:0] KIND_CC = 3'd1;
    localparam logic [2:0] KIND_DT = 3'd2;
    localparam logic [2:0] KIND_DR = 3'd3;
    localparam logic [2:0] KIND_ER = 3'd4;

    // Byte roles
    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_PCODE   = 3'd1;
    localparam logic [2:0] ROLE_PLEN    = 3'd2;
    localparam logic [2:0] ROLE_PVALUE  = 3'd3;
    localparam logic [2:0] ROLE_USER    = 3'd4;

    // Final status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_BAD_LI    = 4'd2;
    localparam logic [3:0] ST_UNKNOWN   = 4'd3;
    localparam logic [3:0] ST_DATA_LI   = 4'd4;
    localparam logic [3:0] ST_REF_SHORT = 4'd5;
    localparam logic [3:0] ST_TRUNC     = 4'd6;
    localparam logic [3:0] ST_OVERRUN   = 4'd7;
    localparam logic [3:0] ST_CONN_DATA = 4'd8;

    // Header layout
    localparam logic [7:0] DT_HEADER_LEN  = 8'd2;
    localparam logic [7:0] REF_HEADER_LEN = 8'd6;
    localparam logic [8:0] LAST_FIXED_POS = 9'd6;
    localparam logic [8:0] POS_SATURATE   = 9'd256;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified byte as it leaves the front end
    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  data_byte;
        logic [7:0]  current_param;
        logic        done_res;
        logic [3:0]  status;
        logic [2:0]  kind;
        logic [7:0]  eot_number;
        logic [15:0] dest_ref;
        logic [15:0] src_ref;
        logic [7:0]  class_reason;
    } tpdu_entry_t;

    // One formatted result
    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  data_byte;
        logic [7:0]  current_param;
        logic        done_res;
        logic [3:0]  status;
        logic [2:0]  kind;
        logic        end_flag;
        logic [6:0]  seq_number;
        logic [15:0] dest_ref;
        logic [15:0] src_ref;
        logic [7:0]  class_reason;
    } tpdu_res_t;

endpackage

`default_nettype wire

// ===== rtl/tpdu_hp_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tpdu_hp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, output byte_value, output last, input ready);
    modport sink   (input valid, input byte_value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tpdu_hp_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tpdu_hp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  role;
    logic [7:0]  data_byte;
    logic [7:0]  current_param;
    logic        done_res;
    logic [3:0]  status;
    logic [2:0]  kind;
    logic        end_flag;
    logic [6:0]  seq_number;
    logic [15:0] dest_ref;
    logic [15:0] src_ref;
    logic [7:0]  class_reason;

    modport source (
        output valid, output role, output data_byte, output current_param,
        output done_res, output status, output kind, output end_flag,
        output seq_number, output dest_ref, output src_ref, output class_reason,
        input ready
    );
    modport sink (
        input valid, input role, input data_byte, input current_param,
        input done_res, input status, input kind, input end_flag,
        input seq_number, input dest_ref, input src_ref, input class_reason,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/transport_tpdu_header_parser_core.sv =====
// Transport TPDU header parser.
// byte_in carries the bytes of one TPDU in order, one transaction per byte,
// with last set on the final byte. res_out returns one transaction per byte:
// the byte, its role (fixed header, parameter code, length, value or user
// data) and the parameter code it belongs to. On the final byte done_res is
// set with the status, and when the status is zero the decoded kind, EOT,
// number, references and class or reason follow; they read zero otherwise.
// An accepted byte is written into the queue and then into the output register
// once that register is empty or is being taken; when nothing stalls, throughput
// is one byte per cycle. The per-byte classification is a handful of
// compares, a position counter and two 8-bit subtracts in the front end.
// Reset clears the parser state, empties the two-entry queue and drops
// res_out.valid. When the receiver holds ready low, the queue and the output
// register absorb up to three bytes before byte_in.ready falls; nothing is
// lost or repeated, and the next TPDU starts right after a last byte.
`timescale 1ns / 1ps
`default_nettype none

module transport_tpdu_header_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tpdu_hp_byte_if.sink    byte_in,
    tpdu_hp_res_if.source   res_out
);
    import tpdu_hp_pkg::*;

    tpdu_entry_t  front_entry;
    tpdu_entry_t  back_entry;
    logic         push;
    logic         full;
    logic         pop;
    logic         not_empty;

    // Accept and classify bytes
    tpdu_hp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .entry   (front_entry),
        .push    (push),
        .full    (full)
    );

    // Decouple front and back
    tpdu_hp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .full      (full),
        .pop       (pop),
        .entry_out (back_entry),
        .not_empty (not_empty)
    );

    // Format and present results
    tpdu_hp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (back_entry),
        .entry_valid (not_empty),
        .pop         (pop),
        .res_out     (res_out)
    );

endmodule

`default_nettype wire

// ===== rtl/tpdu_hp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "transport_tpdu_header_parser_core_assert.svh"

module tpdu_hp_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    tpdu_hp_byte_if.sink                  byte_in,
    output tpdu_hp_pkg::tpdu_entry_t      entry,
    output logic                          push,
    input  wire logic                     full
);
    import tpdu_hp_pkg::*;

    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [1:0] PERR_NONE  = 2'd0;
    localparam logic [1:0] PERR_TRUNC = 2'd1;
    localparam logic [1:0] PERR_OVER  = 2'd2;

    logic [8:0]  pos_reg,   pos_next;
    logic [7:0]  hlen_reg,  hlen_next;
    logic [2:0]  kind_reg,  kind_next;
    logic        known_reg, known_next;
    logic [15:0] dest_reg,  dest_next;
    logic [15:0] src_reg,   src_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  eot_reg,   eot_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  pcode_reg, pcode_next;
    logic [7:0]  prem_reg,  prem_next;
    logic [1:0]  perr_reg,  perr_next;

    logic        accept;
    logic [8:0]  idx;
    logic [7:0]  b;
    logic        is_data;
    logic [2:0]  role;
    logic [7:0]  cur;
    logic [3:0]  status;
    logic [8:0]  hlen_ext;
    logic [8:0]  hlen_next_ext;
    logic [7:0]  room;

    // Map a code byte to its kind
    function automatic logic classify(input logic [7:0] code, output logic [2:0] k);
        logic ok;
        ok = 1'b1;
        unique case (code)
            CODE_CR: k = KIND_CR;
            CODE_CC: k = KIND_CC;
            CODE_DT: k = KIND_DT;
            CODE_DR: k = KIND_DR;
            CODE_ER: k = KIND_ER;
            default:
            begin
                k  = KIND_CR;
                ok = 1'b0;
            end
        endcase
        return ok;
    endfunction

    assign byte_in.ready = !full;
    assign accept        = byte_in.valid && !full;
    assign push          = accept;

    assign idx      = pos_reg;
    assign b        = byte_in.byte_value;
    assign hlen_ext = {1'b0, hlen_reg};
    assign room     = hlen_reg - idx[7:0];

    // Classify the byte and compute the next parser state
    always_comb
    begin
        pos_next   = (pos_reg < POS_SATURATE) ? pos_reg + 9'd1 : pos_reg;
        hlen_next  = hlen_reg;
        kind_next  = kind_reg;
        known_next = known_reg;
        dest_next  = dest_reg;
        src_next   = src_reg;
        class_next = class_reg;
        eot_next   = eot_reg;
        phase_next = phase_reg;
        pcode_next = pcode_reg;
        prem_next  = prem_reg;
        perr_next  = perr_reg;
        role       = ROLE_HEADER;
        cur        = 8'd0;

        // Capture fixed header fields
        if (idx == 9'd0)
        begin
            hlen_next = b;
        end
        else if (idx == 9'd1)
        begin
            known_next = classify(b, kind_next);
        end
        else if (idx == 9'd2)
        begin
            eot_next  = b;
            dest_next = {b, dest_reg[7:0]};
        end
        else if (idx == 9'd3)
        begin
            dest_next = {dest_reg[15:8], b};
        end
        else if (idx == 9'd4)
        begin
            src_next = {b, src_reg[7:0]};
        end
        else if (idx == 9'd5)
        begin
            src_next = {src_reg[15:8], b};
        end
        else if (idx == LAST_FIXED_POS)
        begin
            class_next = b;
        end

        // Tag the byte and walk the parameter list
        is_data = (idx >= 9'd2) && known_reg && (kind_reg == KIND_DT);
        if (idx < 9'd2)
        begin
            role = ROLE_HEADER;
        end
        else if (is_data)
        begin
            role = (idx == 9'd2) ? ROLE_HEADER : ROLE_USER;
        end
        else if (idx <= LAST_FIXED_POS)
        begin
            role = ROLE_HEADER;
        end
        else if (idx > hlen_ext)
        begin
            role = ROLE_USER;
        end
        else
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    role       = ROLE_PCODE;
                    cur        = b;
                    pcode_next = b;
                    if (idx == hlen_ext)
                    begin
                        if (perr_reg == PERR_NONE)
                        begin
                            perr_next = PERR_TRUNC;
                        end
                        phase_next = PH_CODE;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    role      = ROLE_PLEN;
                    cur       = pcode_reg;
                    prem_next = b;
                    if ((b > room) && (perr_reg == PERR_NONE))
                    begin
                        perr_next = PERR_OVER;
                    end
                    phase_next = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
                default:
                begin
                    role      = ROLE_PVALUE;
                    cur       = pcode_reg;
                    prem_next = prem_reg - 8'd1;
                    if (prem_next == 8'd0)
                    begin
                        phase_next = PH_CODE;
                    end
                end
            endcase
        end
    end

    assign hlen_next_ext = {1'b0, hlen_next};

    // Work out the final status in check order
    always_comb
    begin
        status = ST_OK;
        if (byte_in.last)
        begin
            if (idx == 9'd0)
            begin
                status = ST_SHORT;
            end
            else if ((hlen_next < DT_HEADER_LEN) || (hlen_next_ext > idx))
            begin
                status = ST_BAD_LI;
            end
            else if (!known_next)
            begin
                status = ST_UNKNOWN;
            end
            else if (kind_next == KIND_DT)
            begin
                status = (hlen_next != DT_HEADER_LEN) ? ST_DATA_LI : ST_OK;
            end
            else if (hlen_next < REF_HEADER_LEN)
            begin
                status = ST_REF_SHORT;
            end
            else if (perr_next == PERR_TRUNC)
            begin
                status = ST_TRUNC;
            end
            else if (perr_next == PERR_OVER)
            begin
                status = ST_OVERRUN;
            end
            else if (((kind_next == KIND_CR) || (kind_next == KIND_CC)) &&
                     (idx > hlen_next_ext))
            begin
                status = ST_CONN_DATA;
            end
        end
    end

    // Build the queue transaction
    always_comb
    begin
        entry.role          = role;
        entry.data_byte     = b;
        entry.current_param = cur;
        entry.done_res      = byte_in.last;
        entry.status        = status;
        entry.kind          = kind_next;
        entry.eot_number    = eot_next;
        entry.dest_ref      = dest_next;
        entry.src_ref       = src_next;
        entry.class_reason  = class_next;
    end

    // Advance the parser on each accepted byte, clear it after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hlen_reg  <= '0;
            kind_reg  <= KIND_CR;
            known_reg <= 1'b0;
            dest_reg  <= '0;
            src_reg   <= '0;
            class_reg <= '0;
            eot_reg   <= '0;
            phase_reg <= PH_CODE;
            pcode_reg <= '0;
            prem_reg  <= '0;
            perr_reg  <= PERR_NONE;
        end
        else if (accept)
        begin
            if (byte_in.last)
            begin
                pos_reg   <= '0;
                hlen_reg  <= '0;
                kind_reg  <= KIND_CR;
                known_reg <= 1'b0;
                dest_reg  <= '0;
                src_reg   <= '0;
                class_reg <= '0;
                eot_reg   <= '0;
                phase_reg <= PH_CODE;
                pcode_reg <= '0;
                prem_reg  <= '0;
                perr_reg  <= PERR_NONE;
            end
            else
            begin
                pos_reg   <= pos_next;
                hlen_reg  <= hlen_next;
                kind_reg  <= kind_next;
                known_reg <= known_next;
                dest_reg  <= dest_next;
                src_reg   <= src_next;
                class_reg <= class_next;
                eot_reg   <= eot_next;
                phase_reg <= phase_next;
                pcode_reg <= pcode_next;
                prem_reg  <= prem_next;
                perr_reg  <= perr_next;
            end
        end
    end

    `TPDU_ASSERT_NXT(a_front_clear, accept && byte_in.last, (pos_reg == 9'd0) && (phase_reg == PH_CODE) && (perr_reg == PERR_NONE), "parser state not cleared after last byte")
    `TPDU_ASSERT_IMP(a_front_sat, 1'b1, pos_reg <= POS_SATURATE, "position counter past saturation")

endmodule

`default_nettype wire

// ===== rtl/tpdu_hp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "transport_tpdu_header_parser_core_assert.svh"

module tpdu_hp_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire tpdu_hp_pkg::tpdu_entry_t entry_in,
    output logic                          full,
    input  wire logic                     pop,
    output tpdu_hp_pkg::tpdu_entry_t      entry_out,
    output logic                          not_empty
);
    import tpdu_hp_pkg::*;

    tpdu_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg,  count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign entry_out = mem[rd_ptr_reg];

    // Step pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    `TPDU_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue occupancy out of range")

endmodule

`default_nettype wire

// ===== rtl/tpdu_hp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "transport_tpdu_header_parser_core_assert.svh"

module tpdu_hp_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tpdu_hp_pkg::tpdu_entry_t entry,
    input  wire logic                     entry_valid,
    output logic                          pop,
    tpdu_hp_res_if.source                 res_out
);
    import tpdu_hp_pkg::*;

    logic       out_valid_reg, out_valid_next;
    tpdu_res_t  res_reg, res_next;
    logic       load;
    logic       ok;
    logic       dt;

    assign load = entry_valid && (!out_valid_reg || res_out.ready);
    assign pop  = load;
    assign ok   = entry.done_res && (entry.status == ST_OK);
    assign dt   = (entry.kind == KIND_DT);

    // Format the result; decoded fields stay zero unless the final byte has status OK
    always_comb
    begin
        res_next.role          = entry.role;
        res_next.data_byte     = entry.data_byte;
        res_next.current_param = entry.current_param;
        res_next.done_res      = entry.done_res;
        res_next.status        = entry.status;
        res_next.kind          = ok ? entry.kind : 3'd0;
        res_next.end_flag      = ok && (dt ? entry.eot_number[7] : 1'b1);
        res_next.seq_number    = (ok && dt) ? entry.eot_number[6:0] : 7'd0;
        res_next.dest_ref      = (ok && !dt) ? entry.dest_ref : 16'd0;
        res_next.src_ref       = (ok && !dt) ? entry.src_ref : 16'd0;
        res_next.class_reason  = (ok && !dt) ? entry.class_reason : 8'd0;
    end

    // Drop valid once taken, refill from the queue
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.role          = res_reg.role;
    assign res_out.data_byte     = res_reg.data_byte;
    assign res_out.current_param = res_reg.current_param;
    assign res_out.done_res      = res_reg.done_res;
    assign res_out.status        = res_reg.status;
    assign res_out.kind          = res_reg.kind;
    assign res_out.end_flag      = res_reg.end_flag;
    assign res_out.seq_number    = res_reg.seq_number;
    assign res_out.dest_ref      = res_reg.dest_ref;
    assign res_out.src_ref       = res_reg.src_ref;
    assign res_out.class_reason  = res_reg.class_reason;

    `TPDU_ASSERT_IMP(a_back_status, out_valid_reg && (res_reg.status != ST_OK), res_reg.done_res, "status reported on a non-final byte")
    `TPDU_ASSERT_IMP(a_back_fields, out_valid_reg && !res_reg.done_res, (res_reg.kind == 3'd0) && !res_reg.end_flag && (res_reg.dest_ref == 16'd0), "decoded fields set on a non-final byte")

endmodule

`default_nettype wire
